/* sv/gps_assist_request_parser_top_defines.svh */
// assertion helpers for the request parser
`ifndef GPS_ASSIST_REQUEST_PARSER_TOP_DEFINES_SVH
`define GPS_ASSIST_REQUEST_PARSER_TOP_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define GAPR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define GAPR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* sv/gapr_pkg.sv */
package gapr_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic        want_almanac;
        logic        want_utc_model;
        logic        want_iono_model;
        logic        want_ref_location;
        logic        want_ref_time;
        logic        want_ephemeris;
        logic [63:0] satellite_mask;
        logic        unsupported_seen;
    } t_out;

    // parse phases
    localparam logic [2:0] PH_HDR0  = 3'd0;
    localparam logic [2:0] PH_HDR1  = 3'd1;
    localparam logic [2:0] PH_NAV   = 3'd2;
    localparam logic [2:0] PH_SV    = 3'd3;
    localparam logic [2:0] PH_EXT   = 3'd4;
    localparam logic [2:0] PH_CHK   = 3'd5;
    localparam logic [2:0] PH_DONE  = 3'd6;
    localparam logic [2:0] PH_TRAIL = 3'd7;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_SHORT = 2'd1;
    localparam logic [1:0] ST_TRAIL = 2'd2;

    // header flag bits
    localparam logic [7:0] LOW_ALMANAC = 8'h01;
    localparam logic [7:0] LOW_UTC     = 8'h02;
    localparam logic [7:0] LOW_IONO    = 8'h04;
    localparam logic [7:0] LOW_NAV     = 8'h08;
    localparam logic [7:0] LOW_DGPS    = 8'h10;
    localparam logic [7:0] LOW_REFLOC  = 8'h20;
    localparam logic [7:0] LOW_REFTIME = 8'h40;
    localparam logic [7:0] LOW_ACQ     = 8'h80;
    localparam logic [7:0] HIGH_RTI    = 8'h01;
    localparam logic [7:0] HIGH_EXT    = 8'h02;
    localparam logic [7:0] HIGH_CHK    = 8'h04;

    localparam logic [1:0] NAV_LAST_IDX = 2'd3;
    localparam logic [1:0] CHK_LAST_IDX = 2'd2;

    // phase that follows a finished header, nav or ext section
    function automatic logic [2:0] phase_after(input logic [2:0] done,
                                               input logic [7:0] fl,
                                               input logic [7:0] fh);
        logic [2:0] ph;
        priority if (done == PH_HDR1 && (fl & LOW_NAV) != 8'd0) begin
            ph = PH_NAV;
        end else if ((done == PH_HDR1 || done == PH_NAV) && (fh & HIGH_EXT) != 8'd0) begin
            ph = PH_EXT;
        end else if ((fh & HIGH_CHK) != 8'd0) begin
            ph = PH_CHK;
        end else begin
            ph = PH_DONE;
        end
        return ph;
    endfunction

endpackage

/* sv/gapr_in_stage.sv */
module gapr_in_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  gapr_pkg::t_in i_data,
    output logic          o_stall,
    input  logic          i_advance,
    output logic          o_valid,
    output gapr_pkg::t_in o_data
);

    logic          r_valid;
    gapr_pkg::t_in r_data;
    logic          w_load;

    assign o_stall = r_valid && !i_advance;
    assign w_load  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

/* sv/gapr_parse.sv */
module gapr_parse (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  gapr_pkg::t_in  i_data,
    input  logic           i_out_free,
    output logic           o_advance,
    output logic           o_load,
    output gapr_pkg::t_out o_result
);

    logic [2:0]  r_phase;
    logic [7:0]  r_flags_low;
    logic [7:0]  r_flags_high;
    logic [1:0]  r_sec_idx;
    logic [3:0]  r_entries_left;
    logic        r_entry_odd;
    logic [63:0] r_mask;

    logic [2:0]  n_phase;
    logic [7:0]  n_flags_low;
    logic [7:0]  n_flags_high;
    logic [1:0]  n_sec_idx;
    logic [3:0]  n_entries_left;
    logic        n_entry_odd;
    logic [63:0] n_mask;

    logic [7:0]  w_b;
    logic [5:0]  w_id;
    logic [3:0]  w_dec;

    assign w_b   = i_data.data_byte;
    assign w_id  = w_b[5:0];
    assign w_dec = r_entries_left - 4'd1;

    // a non-last word never needs the result register
    assign o_advance = i_valid && (!i_data.last_byte || i_out_free);
    assign o_load    = o_advance && i_data.last_byte;

    always_comb begin
        n_phase        = r_phase;
        n_flags_low    = r_flags_low;
        n_flags_high   = r_flags_high;
        n_sec_idx      = r_sec_idx;
        n_entries_left = r_entries_left;
        n_entry_odd    = r_entry_odd;
        n_mask         = r_mask;
        unique case (r_phase)
            gapr_pkg::PH_HDR0: begin
                n_flags_low = w_b;
                n_phase     = gapr_pkg::PH_HDR1;
            end
            gapr_pkg::PH_HDR1: begin
                n_flags_high = w_b;
                n_phase      = gapr_pkg::phase_after(gapr_pkg::PH_HDR1, r_flags_low, w_b);
            end
            gapr_pkg::PH_NAV: begin
                if (r_sec_idx == gapr_pkg::NAV_LAST_IDX) begin
                    n_sec_idx      = 2'd0;
                    n_entries_left = w_b[7:4];
                    n_entry_odd    = 1'b0;
                    n_phase        = (w_b[7:4] != 4'd0) ? gapr_pkg::PH_SV :
                        gapr_pkg::phase_after(gapr_pkg::PH_NAV, r_flags_low, r_flags_high);
                end else begin
                    n_sec_idx = r_sec_idx + 2'd1;
                end
            end
            gapr_pkg::PH_SV: begin
                if (!r_entry_odd) begin
                    // id zero sets no bit
                    if (w_id != 6'd0) begin
                        n_mask = r_mask | (64'd1 << (w_id - 6'd1));
                    end
                    n_entry_odd = 1'b1;
                end else begin
                    n_entry_odd    = 1'b0;
                    n_entries_left = w_dec;
                    if (w_dec == 4'd0) begin
                        n_phase = gapr_pkg::phase_after(gapr_pkg::PH_NAV, r_flags_low,
                                                        r_flags_high);
                    end
                end
            end
            gapr_pkg::PH_EXT: begin
                n_phase = gapr_pkg::phase_after(gapr_pkg::PH_EXT, r_flags_low, r_flags_high);
            end
            gapr_pkg::PH_CHK: begin
                if (r_sec_idx == gapr_pkg::CHK_LAST_IDX) begin
                    n_sec_idx = 2'd0;
                    n_phase   = gapr_pkg::PH_DONE;
                end else begin
                    n_sec_idx = r_sec_idx + 2'd1;
                end
            end
            default: begin
                n_phase = gapr_pkg::PH_TRAIL;
            end
        endcase
    end

    always_comb begin
        o_result = '0;
        priority if (n_phase == gapr_pkg::PH_DONE) begin
            o_result.status            = gapr_pkg::ST_OK;
            o_result.want_almanac      = (n_flags_low & gapr_pkg::LOW_ALMANAC) != 8'd0;
            o_result.want_utc_model    = (n_flags_low & gapr_pkg::LOW_UTC) != 8'd0;
            o_result.want_iono_model   = (n_flags_low & gapr_pkg::LOW_IONO) != 8'd0;
            o_result.want_ref_location = (n_flags_low & gapr_pkg::LOW_REFLOC) != 8'd0;
            o_result.want_ref_time     = (n_flags_low & gapr_pkg::LOW_REFTIME) != 8'd0;
            o_result.want_ephemeris    = (n_flags_low & gapr_pkg::LOW_NAV) != 8'd0;
            o_result.satellite_mask    = n_mask;
            o_result.unsupported_seen  =
                ((n_flags_low & (gapr_pkg::LOW_DGPS | gapr_pkg::LOW_ACQ)) != 8'd0) ||
                ((n_flags_high & (gapr_pkg::HIGH_RTI | gapr_pkg::HIGH_EXT |
                                  gapr_pkg::HIGH_CHK)) != 8'd0);
        end else if (n_phase == gapr_pkg::PH_TRAIL) begin
            o_result.status = gapr_pkg::ST_TRAIL;
        end else begin
            o_result.status = gapr_pkg::ST_SHORT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_load) begin
            // last word of a message restarts the parse
            r_phase        <= gapr_pkg::PH_HDR0;
            r_flags_low    <= 8'd0;
            r_flags_high   <= 8'd0;
            r_sec_idx      <= 2'd0;
            r_entries_left <= 4'd0;
            r_entry_odd    <= 1'b0;
            r_mask         <= 64'd0;
        end else if (o_advance) begin
            r_phase        <= n_phase;
            r_flags_low    <= n_flags_low;
            r_flags_high   <= n_flags_high;
            r_sec_idx      <= n_sec_idx;
            r_entries_left <= n_entries_left;
            r_entry_odd    <= n_entry_odd;
            r_mask         <= n_mask;
        end
    end

endmodule

/* sv/gapr_out_stage.sv */
module gapr_out_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  gapr_pkg::t_out i_result,
    output logic           o_free,
    output logic           o_valid,
    output gapr_pkg::t_out o_data,
    input  logic           i_stall
);

    logic           r_valid;
    gapr_pkg::t_out r_data;

    assign o_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_result;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

/* sv/gps_assist_request_parser_top.sv */
// gps assistance request parser
// input channel: one message byte per word with a last-byte flag
// (i_in_valid / i_in_data, stall back on o_in_stall). output channel: one
// result word per message (o_out_valid / o_out_data, stall in on i_out_stall),
// carrying status, requested-element flags, the satellite mask and the
// unsupported-request flag; on a short or overlong message only the status is
// nonzero.
// one word is accepted every cycle while o_in_stall is low. each word is held
// in the input register; when it advances, the parse state and the result
// register update together, so a result is offered once its last byte leaves
// the input register. bytes that are not last never wait on the output side.
// the output register lets the next bytes flow while a result waits; only a
// last byte that finds the result register full and stalled holds the input
// register, and the input stall then rises.
// synchronous reset clears both valid flags and returns the parser to the
// first header byte; a partly received message is dropped.
`include "gps_assist_request_parser_top_defines.svh"

module gps_assist_request_parser_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  gapr_pkg::t_in  i_in_data,
    output logic           o_in_stall,
    output logic           o_out_valid,
    output gapr_pkg::t_out o_out_data,
    input  logic           i_out_stall
);

    logic           w_st_valid;
    gapr_pkg::t_in  w_st_data;
    logic           w_advance;
    logic           w_load;
    logic           w_out_free;
    gapr_pkg::t_out w_result;

    gapr_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .i_data    (i_in_data),
        .o_stall   (o_in_stall),
        .i_advance (w_advance),
        .o_valid   (w_st_valid),
        .o_data    (w_st_data)
    );

    gapr_parse u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_st_valid),
        .i_data     (w_st_data),
        .i_out_free (w_out_free),
        .o_advance  (w_advance),
        .o_load     (w_load),
        .o_result   (w_result)
    );

    gapr_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_load),
        .i_result (w_result),
        .o_free   (w_out_free),
        .o_valid  (o_out_valid),
        .o_data   (o_out_data),
        .i_stall  (i_out_stall)
    );

    `GAPR_ASSERT_NOW(a_stall_full, o_in_stall, o_out_valid && i_out_stall, "stall, output free")
    `GAPR_ASSERT_NEXT(a_last_gives_result, w_load, o_out_valid, "no result after last byte")
    `GAPR_ASSERT_NEXT(a_no_extra, o_out_valid && !i_out_stall && !w_load, !o_out_valid, "stray")

endmodule
